/* src/qapm_pkg.sv */
// Package for the quad attitude PID mixer: stage payload types, field widths,
// register codes and reset values. No dependencies.
package qapm_pkg;

  localparam int ValW   = 20;  // Q12.8 errors, angles, rates
  localparam int GainW  = 16;  // Q8.8 gains and the Q.8 clear band
  localparam int ThrInW = 8;   // base throttle step
  localparam int ProdW  = 37;  // 17-bit signed gain times 20-bit value
  localparam int StepW  = 29;  // integral step, product floored to Q.8
  localparam int LimW   = 23;  // integral limit magnitude
  localparam int IntegW = 24;  // clamped integral, signed Q.8
  localparam int PdW    = 38;  // kp*err - kd*rate, Q.16
  localparam int TermW  = 39;  // full axis term, Q.16
  localparam int ThrW   = 13;  // (base-1)*10
  localparam int MotorW = 16;

  localparam logic [LimW-1:0] LIM_STEP = 23'd25600;  // 100.0 in Q.8

  localparam logic [GainW-1:0] PROP_GAIN_RST  = 16'd1280;
  localparam logic [GainW-1:0] INTEG_GAIN_RST = 16'd0;
  localparam logic [GainW-1:0] DERIV_GAIN_RST = 16'd512;
  localparam logic [GainW-1:0] CLEAR_BAND_RST = 16'd26;

  // Largest limit the clamp can ever produce (pitch axis, full-scale error)
  localparam logic signed [IntegW-1:0] INTEG_MAX = 24'sd5294080;

  typedef enum logic [1:0] {
    REG_PROP_GAIN  = 2'd0,
    REG_INTEG_GAIN = 2'd1,
    REG_DERIV_GAIN = 2'd2,
    REG_CLEAR_BAND = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [ValW-1:0]   roll_error;
    logic signed [ValW-1:0]   pitch_error;
    logic signed [ValW-1:0]   roll_angle;
    logic signed [ValW-1:0]   pitch_angle;
    logic signed [ValW-1:0]   roll_rate;
    logic signed [ValW-1:0]   pitch_rate;
    logic signed [ThrInW-1:0] base_throttle;
  } in_beat_t;

  typedef struct packed {
    logic signed [ProdW-1:0] kp_roll;
    logic signed [ProdW-1:0] kp_pitch;
    logic signed [ProdW-1:0] kd_roll;
    logic signed [ProdW-1:0] kd_pitch;
    logic signed [StepW-1:0] step_roll;
    logic signed [StepW-1:0] step_pitch;
    logic                    clr_roll;
    logic                    clr_pitch;
    logic [LimW-1:0]         lim_roll;
    logic [LimW-1:0]         lim_pitch;
    logic signed [ThrW-1:0]  thr;
    logic                    on;
  } prod_t;

  typedef struct packed {
    logic signed [PdW-1:0]    pd_roll;
    logic signed [PdW-1:0]    pd_pitch;
    logic signed [IntegW-1:0] integ_roll;
    logic signed [IntegW-1:0] integ_pitch;
    logic signed [ThrW-1:0]   thr;
    logic                     on;
  } integ_stage_t;

  typedef struct packed {
    logic signed [TermW-1:0] term_roll;
    logic signed [TermW-1:0] term_pitch;
    logic signed [ThrW-1:0]  thr;
    logic                    on;
  } term_stage_t;

endpackage

/* src/quad_attitude_pid_mixer.sv */
// Quad attitude PID mixer top level: roll/pitch PID with integral clamp and
// a four-motor plus-mixer, five-register pipeline. Depends on qapm_pkg.
//
// Usage
//   Input stream (s_*): one beat per control tick carrying the six Q12.8
//   roll/pitch errors, angles and gyro rates plus the signed base throttle.
//   Output stream (m_*): one beat per input beat with the four saturated
//   int16 motor drives, in input order.
//   Config (APB): prop_gain at 0x0, integ_gain at 0x4, deriv_gain at 0x8,
//   integ_clear_band at 0xC; low 16 bits of pwdata are kept. Write only
//   while no beat is in flight.
// Timing
//   One beat is taken every cycle while m_tready is high: products,
//   integral update, term sum and motor mix each own one stage. The
//   integral feedback loop is a single add and clamp inside the integral
//   stage, so back-to-back ticks see each other's integral.
// Reset
//   Gains return to 5.0 / 0.0 / 2.0, band to 26, both integrals to zero and
//   every stage is emptied.
// Stall
//   A held output beat stalls only the stages behind it that are full;
//   bubbles still close up, and s_tready drops once all five stages hold
//   a beat.
module quad_attitude_pid_mixer (
  input  logic         clk,
  input  logic         rst,
  // Input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // [19:0] roll_error, [39:20] pitch_error, [59:40] roll_angle,
  // [79:60] pitch_angle, [99:80] roll_rate, [119:100] pitch_rate,
  // [127:120] base_throttle
  input  logic [127:0] s_tdata,
  // Output stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // [15:0] motor_a, [31:16] motor_b, [47:32] motor_c, [63:48] motor_d
  output logic [63:0]  m_tdata,
  // Config port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  import qapm_pkg::*;

  // ---------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------

  // Clear (if inside the band), take the step off and clamp to +/- lim.
  function automatic logic signed [IntegW-1:0] integ_update(
    input logic signed [IntegW-1:0] cur,
    input logic                     clr,
    input logic signed [StepW-1:0]  step,
    input logic [LimW-1:0]          lim
  );
    logic signed [StepW:0]  base_v;
    logic signed [StepW:0]  sum;
    logic signed [StepW:0]  lim_v;
    logic signed [IntegW-1:0] res;
    base_v = clr ? '0 : (StepW+1)'(cur);
    sum    = base_v - (StepW+1)'(step);
    lim_v  = $signed({{(StepW+1-LimW){1'b0}}, lim});
    if (sum > lim_v) begin
      res = IntegW'(lim_v);
    end else if (sum < -lim_v) begin
      res = IntegW'(-lim_v);
    end else begin
      res = IntegW'(sum);
    end
    return res;
  endfunction

  // Throttle +/- term in Q.16, truncated toward zero, saturated to int16.
  function automatic logic [MotorW-1:0] mix(
    input logic signed [ThrW-1:0]  thr,
    input logic signed [TermW-1:0] term,
    input logic                    neg
  );
    logic signed [40:0] t_v;
    logic signed [40:0] sum;
    logic signed [24:0] q;
    logic [MotorW-1:0]  res;
    t_v = 41'(term);
    sum = {{(41-ThrW-16){thr[ThrW-1]}}, thr, 16'b0} + (neg ? -t_v : t_v);
    q   = sum[40:16] + 25'((sum[40] && (sum[15:0] != 16'b0)) ? 1 : 0);
    if (q > 25'sd32767) begin
      res = 16'h7FFF;
    end else if (q < -25'sd32768) begin
      res = 16'h8000;
    end else begin
      res = q[MotorW-1:0];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [GainW-1:0] prop_gain;
  logic [GainW-1:0] integ_gain;
  logic [GainW-1:0] deriv_gain;
  logic [GainW-1:0] integ_clear_band;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain        <= PROP_GAIN_RST;
      integ_gain       <= INTEG_GAIN_RST;
      deriv_gain       <= DERIV_GAIN_RST;
      integ_clear_band <= CLEAR_BAND_RST;
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(paddr[3:2]))
        REG_PROP_GAIN:  prop_gain        <= pwdata[GainW-1:0];
        REG_INTEG_GAIN: integ_gain       <= pwdata[GainW-1:0];
        REG_DERIV_GAIN: deriv_gain       <= pwdata[GainW-1:0];
        REG_CLEAR_BAND: integ_clear_band <= pwdata[GainW-1:0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_reg_t'(paddr[3:2]))
      REG_PROP_GAIN:  prdata = {16'b0, prop_gain};
      REG_INTEG_GAIN: prdata = {16'b0, integ_gain};
      REG_DERIV_GAIN: prdata = {16'b0, deriv_gain};
      REG_CLEAR_BAND: prdata = {16'b0, integ_clear_band};
    endcase
  end

  // ---------------------------------------------------------------------
  // Stage enables: a stage loads when it is empty or its beat moves on
  // ---------------------------------------------------------------------
  logic v1, v2, v3, v4, vo;
  logic en1, en2, en3, en4, en_o;

  assign en_o     = !vo || m_tready;
  assign en4      = !v4 || en_o;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1;
  assign m_tvalid = vo;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (en1)  v1 <= s_tvalid;
      if (en2)  v2 <= v1;
      if (en3)  v3 <= v2;
      if (en4)  v4 <= v3;
      if (en_o) vo <= v4;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------------
  in_beat_t r1;

  always_ff @(posedge clk) begin
    if (en1) begin
      r1.roll_error    <= s_tdata[19:0];
      r1.pitch_error   <= s_tdata[39:20];
      r1.roll_angle    <= s_tdata[59:40];
      r1.pitch_angle   <= s_tdata[79:60];
      r1.roll_rate     <= s_tdata[99:80];
      r1.pitch_rate    <= s_tdata[119:100];
      r1.base_throttle <= s_tdata[127:120];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: gain products, deadband flags, limits, throttle
  // ---------------------------------------------------------------------
  prod_t                   r2;
  prod_t                   r2_next;
  logic signed [GainW:0]   kp_s, ki_s, kd_s;
  logic signed [ProdW-1:0] ki_roll, ki_pitch;
  logic signed [ValW:0]    band_s;
  logic signed [ValW:0]    ra_s, pa_s;
  logic signed [LimW:0]    re_s, re10;
  logic [LimW-1:0]         re10_abs;
  logic signed [ThrInW:0]  base_m1;

  assign kp_s   = $signed({1'b0, prop_gain});
  assign ki_s   = $signed({1'b0, integ_gain});
  assign kd_s   = $signed({1'b0, deriv_gain});
  assign band_s = $signed({{(ValW+1-GainW){1'b0}}, integ_clear_band});
  assign ra_s   = (ValW+1)'(r1.roll_angle);
  assign pa_s   = (ValW+1)'(r1.pitch_angle);

  // 10*err as 8*err + 2*err, then its magnitude
  assign re_s     = (LimW+1)'(r1.roll_error);
  assign re10     = (re_s <<< 3) + (re_s <<< 1);
  assign re10_abs = re10[LimW] ? LimW'(-re10) : re10[LimW-1:0];
  assign base_m1  = (ThrInW+1)'(r1.base_throttle) - 9'sd1;

  assign ki_roll  = ki_s * r1.roll_angle;
  assign ki_pitch = ki_s * r1.pitch_angle;

  always_comb begin
    r2_next.kp_roll    = kp_s * r1.roll_error;
    r2_next.kp_pitch   = kp_s * r1.pitch_error;
    r2_next.kd_roll    = kd_s * r1.roll_rate;
    r2_next.kd_pitch   = kd_s * r1.pitch_rate;
    // Floor to Q.8: drop the low byte of the signed product
    r2_next.step_roll  = ki_roll[ProdW-1:8];
    r2_next.step_pitch = ki_pitch[ProdW-1:8];
    r2_next.clr_roll   = (ra_s > -band_s) && (ra_s < band_s);
    r2_next.clr_pitch  = (pa_s > -band_s) && (pa_s < band_s);
    r2_next.lim_roll   = re10_abs + LIM_STEP;
    // Pitch limit is roll-derived too, one step wider
    r2_next.lim_pitch  = re10_abs + LIM_STEP + LIM_STEP;
    // Widen before the multiply so 126*10 does not wrap
    r2_next.thr        = ThrW'(base_m1) * 13'sd10;
    r2_next.on         = (r1.base_throttle > 8'sd0);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      r2 <= r2_next;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: integral update (state loop) and P-minus-D sum
  // ---------------------------------------------------------------------
  logic signed [IntegW-1:0] roll_integ, pitch_integ;
  logic signed [IntegW-1:0] roll_integ_next, pitch_integ_next;
  integ_stage_t             r3;

  assign roll_integ_next  = integ_update(roll_integ, r2.clr_roll,
                                         r2.step_roll, r2.lim_roll);
  assign pitch_integ_next = integ_update(pitch_integ, r2.clr_pitch,
                                         r2.step_pitch, r2.lim_pitch);

  // Advance the integrals only when a real beat leaves stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      roll_integ  <= '0;
      pitch_integ <= '0;
    end else if (en3 && v2) begin
      roll_integ  <= roll_integ_next;
      pitch_integ <= pitch_integ_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      r3.pd_roll     <= PdW'(r2.kp_roll) - PdW'(r2.kd_roll);
      r3.pd_pitch    <= PdW'(r2.kp_pitch) - PdW'(r2.kd_pitch);
      r3.integ_roll  <= roll_integ_next;
      r3.integ_pitch <= pitch_integ_next;
      r3.thr         <= r2.thr;
      r3.on          <= r2.on;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: axis term = P - D + integral in Q.16
  // ---------------------------------------------------------------------
  term_stage_t r4;

  always_ff @(posedge clk) begin
    if (en4) begin
      r4.term_roll  <= TermW'(r3.pd_roll) +
                       {{(TermW-IntegW-8){r3.integ_roll[IntegW-1]}},
                        r3.integ_roll, 8'b0};
      r4.term_pitch <= TermW'(r3.pd_pitch) +
                       {{(TermW-IntegW-8){r3.integ_pitch[IntegW-1]}},
                        r3.integ_pitch, 8'b0};
      r4.thr        <= r3.thr;
      r4.on         <= r3.on;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: motor mix into the output register; zero when throttle is off
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en_o) begin
      if (r4.on) begin
        m_tdata <= {mix(r4.thr, r4.term_roll, 1'b0),
                    mix(r4.thr, r4.term_pitch, 1'b1),
                    mix(r4.thr, r4.term_roll, 1'b1),
                    mix(r4.thr, r4.term_pitch, 1'b0)};
      end else begin
        m_tdata <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (v1 && v2 && v3 && v4 && vo))
    else $error("input blocked while a stage is empty");

  a_out_from_stage4: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(v4))
    else $error("output beat appeared without a beat in the term stage");

  a_roll_integ_bound: assert property (@(posedge clk) disable iff (rst)
    (roll_integ <= INTEG_MAX) && (roll_integ >= -INTEG_MAX))
    else $error("roll integral escaped its clamp");

  a_pitch_integ_bound: assert property (@(posedge clk) disable iff (rst)
    (pitch_integ <= INTEG_MAX) && (pitch_integ >= -INTEG_MAX))
    else $error("pitch integral escaped its clamp");

endmodule
